[src/bounded_priority_queue_fifo_tiebreak_core_defines.svh]
// Assertion macros shared by the queue core.
`ifndef BOUNDED_PRIORITY_QUEUE_FIFO_TIEBREAK_CORE_DEFINES_SVH
`define BOUNDED_PRIORITY_QUEUE_FIFO_TIEBREAK_CORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define BPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define BPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bpq_pkg.sv]
`default_nettype none

package bpq_pkg;

    localparam int PRIO_W     = 8;
    localparam int QOS_W      = 2;
    localparam int SEQ_W      = 32;
    localparam int TAG_PORT_W = 16;

    typedef enum logic
    {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } op_t;

    // Ordering key: priority first, then insert sequence (older wins)
    typedef struct packed
    {
        logic [PRIO_W-1:0] prio;
        logic [SEQ_W-1:0]  seq;
    } key_t;

    // Per-transfer command broadcast to every cell
    typedef struct packed
    {
        logic insert;
        logic extract;
    } cell_ctrl_t;

    function automatic logic more_urgent(input key_t a, input key_t b);
        logic res;
        if (a.prio != b.prio)
        begin
            res = a.prio > b.prio;
        end
        else
        begin
            res = a.seq < b.seq;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[src/bpq_cell.sv]
`default_nettype none

// One slot of the sorted row. Slot 0 is the most urgent entry; an insert
// pushes every less urgent entry one slot down, an extract pulls all up.
module bpq_cell #(
    parameter int TAG_W = 16
) (
    input  wire logic                          clk,
    input  wire bpq_pkg::cell_ctrl_t           ctrl,
    input  wire logic                          live,
    input  wire bpq_pkg::key_t                 new_key,
    input  wire logic [bpq_pkg::QOS_W-1:0]     new_qos,
    input  wire logic [TAG_W-1:0]              new_tag,
    input  wire logic                          prev_beats,
    input  wire bpq_pkg::key_t                 prev_key,
    input  wire logic [bpq_pkg::QOS_W-1:0]     prev_qos,
    input  wire logic [TAG_W-1:0]              prev_tag,
    input  wire bpq_pkg::key_t                 succ_key,
    input  wire logic [bpq_pkg::QOS_W-1:0]     succ_qos,
    input  wire logic [TAG_W-1:0]              succ_tag,
    output logic                               beats,
    output bpq_pkg::key_t                      key,
    output logic [bpq_pkg::QOS_W-1:0]          qos,
    output logic [TAG_W-1:0]                   tag
);

    bpq_pkg::key_t                 key_reg;
    logic [bpq_pkg::QOS_W-1:0]     qos_reg;
    logic [TAG_W-1:0]              tag_reg;
    bpq_pkg::key_t                 key_next;
    logic [bpq_pkg::QOS_W-1:0]     qos_next;
    logic [TAG_W-1:0]              tag_next;

    // New entry belongs at or above this slot
    assign beats = !live || bpq_pkg::more_urgent(new_key, key_reg);

    // Select shift source
    always_comb
    begin
        key_next = key_reg;
        qos_next = qos_reg;
        tag_next = tag_reg;
        if (ctrl.insert && beats)
        begin
            if (prev_beats)
            begin
                key_next = prev_key;
                qos_next = prev_qos;
                tag_next = prev_tag;
            end
            else
            begin
                key_next = new_key;
                qos_next = new_qos;
                tag_next = new_tag;
            end
        end
        else if (ctrl.extract)
        begin
            key_next = succ_key;
            qos_next = succ_qos;
            tag_next = succ_tag;
        end
    end

    // Hold slot contents
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        qos_reg <= qos_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign qos = qos_reg;
    assign tag = tag_reg;

endmodule

`default_nettype wire

[src/bounded_priority_queue_fifo_tiebreak_core.sv]
// Channel   Handshake              Payload
// --------  ---------------------  ---------------------------------------------
// request   req_valid / req_stall  op, entry_priority, entry_qos, entry_tag
// response  rsp_valid / rsp_stall  op_ok, item_*, fill_count, top_priority, top_tag
//
// All cells compare and shift at the request edge, and the response is
// valid from the next cycle; fill count and top entry are read from the
// row, which holds still while the response waits.
// rst_n clears the fill count, the sequence counter and the response valid;
// slot contents are not reset and are never read above the fill count.
// A stalled response holds the request side off only while it is not taken.
`default_nettype none

`include "bounded_priority_queue_fifo_tiebreak_core_defines.svh"

module bounded_priority_queue_fifo_tiebreak_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 req_valid,
    output logic                                      req_stall,
    input  wire logic                                 op,
    input  wire logic [bpq_pkg::PRIO_W-1:0]           entry_priority,
    input  wire logic [bpq_pkg::QOS_W-1:0]            entry_qos,
    input  wire logic [bpq_pkg::TAG_PORT_W-1:0]       entry_tag,
    output logic                                      rsp_valid,
    input  wire logic                                 rsp_stall,
    output logic                                      op_ok,
    output logic [bpq_pkg::PRIO_W-1:0]                item_priority,
    output logic [bpq_pkg::QOS_W-1:0]                 item_qos,
    output logic [bpq_pkg::TAG_PORT_W-1:0]            item_tag,
    output logic [bpq_pkg::SEQ_W-1:0]                 item_sequence,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]          fill_count,
    output logic [bpq_pkg::PRIO_W-1:0]                top_priority,
    output logic [bpq_pkg::TAG_PORT_W-1:0]            top_tag
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W = (TAG_BITS < bpq_pkg::TAG_PORT_W) ? TAG_BITS : bpq_pkg::TAG_PORT_W;

    logic                          accept;
    bpq_pkg::cell_ctrl_t           ctrl;
    bpq_pkg::key_t                 new_key;
    logic                          ins_ok;
    logic                          res_ok;

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [bpq_pkg::SEQ_W-1:0]     seq_reg;
    logic [bpq_pkg::SEQ_W-1:0]     seq_next;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;

    logic                                op_ok_reg;
    logic [bpq_pkg::PRIO_W-1:0]          item_priority_reg;
    logic [bpq_pkg::QOS_W-1:0]           item_qos_reg;
    logic [bpq_pkg::TAG_PORT_W-1:0]      item_tag_reg;
    logic [bpq_pkg::SEQ_W-1:0]           item_sequence_reg;

    logic                          beats    [QUEUE_DEPTH];
    logic                          live     [QUEUE_DEPTH];
    bpq_pkg::key_t                 key      [QUEUE_DEPTH];
    logic [bpq_pkg::QOS_W-1:0]     qos      [QUEUE_DEPTH];
    logic [TAG_W-1:0]              tag      [QUEUE_DEPTH];

    // Take a request whenever the response slot is free or drains now
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign new_key.prio  = entry_priority;
    assign new_key.seq   = seq_reg;
    assign ctrl.insert   = accept && (op == bpq_pkg::OP_INSERT);
    assign ctrl.extract  = accept && (op == bpq_pkg::OP_EXTRACT) && (count_reg != '0);

    // Row of sorted slots
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? 0 : i - 1;
        localparam int SUCC = (i == QUEUE_DEPTH - 1) ? i : i + 1;

        assign live[i] = CNT_W'(i) < count_reg;

        bpq_cell #(
            .TAG_W (TAG_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .live       (live[i]),
            .new_key    (new_key),
            .new_qos    (entry_qos),
            .new_tag    (entry_tag[TAG_W-1:0]),
            .prev_beats ((i == 0) ? 1'b0 : beats[PREV]),
            .prev_key   (key[PREV]),
            .prev_qos   (qos[PREV]),
            .prev_tag   (tag[PREV]),
            .succ_key   (key[SUCC]),
            .succ_qos   (qos[SUCC]),
            .succ_tag   (tag[SUCC]),
            .beats      (beats[i]),
            .key        (key[i]),
            .qos        (qos[i]),
            .tag        (tag[i])
        );
    end

    // Insert lands somewhere unless it loses to the last slot of a full row
    assign ins_ok = beats[QUEUE_DEPTH-1];
    assign res_ok = (op == bpq_pkg::OP_INSERT) ? ins_ok : (count_reg != '0);

    // Advance fill count and sequence
    always_comb
    begin
        count_next = count_reg;
        seq_next   = seq_reg;
        if (ctrl.insert)
        begin
            seq_next = seq_reg + 1'b1;
            if (ins_ok && (count_reg != CNT_W'(QUEUE_DEPTH)))
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (ctrl.extract)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Response valid: set on transfer in, drop on transfer out
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            seq_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            seq_reg       <= seq_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Capture response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_ok_reg <= res_ok;
            if (ctrl.extract)
            begin
                item_priority_reg <= key[0].prio;
                item_qos_reg      <= qos[0];
                item_tag_reg      <= bpq_pkg::TAG_PORT_W'(tag[0]);
                item_sequence_reg <= key[0].seq;
            end
            else
            begin
                item_priority_reg <= '0;
                item_qos_reg      <= '0;
                item_tag_reg      <= '0;
                item_sequence_reg <= '0;
            end
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign op_ok         = op_ok_reg;
    assign item_priority = item_priority_reg;
    assign item_qos      = item_qos_reg;
    assign item_tag      = item_tag_reg;
    assign item_sequence = item_sequence_reg;

    // Report the row state; it only moves on a request transfer
    assign fill_count    = count_reg;
    assign top_priority  = (count_reg != '0) ? key[0].prio : '0;
    assign top_tag       = (count_reg != '0) ? bpq_pkg::TAG_PORT_W'(tag[0]) : '0;

    // Checks
    `BPQ_ASSERT_NEXT(a_seq_advance, clk, rst_n, ctrl.insert, seq_reg == $past(seq_reg) + 1'b1, "sequence did not advance on insert")
    `BPQ_ASSERT_NEXT(a_fill_grow, clk, rst_n, ctrl.insert && (count_reg < CNT_W'(QUEUE_DEPTH)), count_reg == $past(count_reg) + 1'b1, "insert into non-full queue did not grow fill")
    `BPQ_ASSERT_SAME(a_row_order, clk, rst_n, count_reg >= CNT_W'(2), !bpq_pkg::more_urgent(key[1], key[0]), "head slot less urgent than second slot")

endmodule

`default_nettype wire
